/* rtl/event_priority_queue_core_defines.svh */
// assertion macros used by the checker file of the event queue
// no dependencies
`ifndef EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH

// clocked assertion, disabled while reset is low
`define EPQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("event queue assertion failed");

// clocked assertion that is also checked during reset
`define EPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("event queue reset assertion failed");

`endif

/* rtl/epq_pkg.sv */
// types and constants of the event priority queue
// no dependencies
package epq_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_BYTES = 8;
    localparam int ADDR_W        = $clog2(DEPTH);
    localparam int HELD_W        = 4;
    localparam int PAY_W         = 64;
    localparam int IN_W          = 88;
    localparam int OUT_W         = 88;

    localparam logic [PAY_W-1:0] PAYLOAD_MASK = {PAY_W{1'b1}} >> (PAY_W - 8 * PAYLOAD_BYTES);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_POP    = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [1:0] ST_DEAD = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;

    typedef struct packed {
        logic [PAY_W-1:0] payload;
        logic [1:0]       status;
        logic [7:0]       pri;
        logic [7:0]       id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

/* rtl/epq_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module epq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/event_priority_queue_core.sv */
// event queue: an insert answers in the cycle after its accept, a pop passes S_POP first
// clear with c entries of which n survive: n+1 scans over the c entries, then a copy
// back of the n survivors; the scan re-reads the slot ram once per survivor
// one item at a time; ready drops from accept until the result is taken
// reset: synchronous active low, queue empty, slot ram is not cleared
// depends on epq_pkg and epq_ram
module event_priority_queue_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // id[7:0], priority_req[15:8], status_code[17:16], payload[81:18], zero pad
    input  logic [epq_pkg::IN_W-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]                s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_id[7:0], out_priority[15:8], out_status[17:16], out_payload[81:18],
    // held[85:82], zero pad
    output logic [epq_pkg::OUT_W-1:0] m_axis_tdata,
    // ok[0]
    output logic                      m_axis_tuser
);
    import epq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_POP, S_SCAN, S_PICK, S_COPY
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_head, r_count, r_idx, r_rd_off, r_k, r_best_off;
    logic                r_rd_vld, r_found;
    logic [DEPTH-1:0]    r_taken;
    t_entry              r_best;
    logic                r_out_valid, r_out_ok;
    t_entry              r_out_entry;
    logic [HELD_W-1:0]   r_out_held;

    logic                a_we, b_we;
    logic [ADDR_W-1:0]   a_waddr, a_raddr, b_waddr, b_raddr;
    t_entry              a_wdata, a_rdata, b_wdata, b_rdata;
    t_entry              in_entry;
    logic                accept, issue, done, cand;
    logic [ADDR_W-1:0]   lim;

    function automatic logic [ADDR_W-1:0] slot_at(logic [ADDR_W-1:0] base,
                                                   logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (ADDR_W+1)'(DEPTH)) begin
            s = s - (ADDR_W+1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

    assign s_axis_tready = (r_state == S_IDLE) && !r_out_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_entry      = '{payload: s_axis_tdata[81:18] & PAYLOAD_MASK,
                             status:  s_axis_tdata[17:16],
                             pri:     s_axis_tdata[15:8],
                             id:      s_axis_tdata[7:0]};

    // scan walks the queued entries, copy walks the sorted survivors
    assign lim   = (r_state == S_COPY) ? r_k : r_count;
    assign issue = r_idx < lim;
    assign done  = !issue && !r_rd_vld;
    assign cand  = r_rd_vld && !r_taken[r_rd_off] && (a_rdata.status != ST_DEAD) &&
                   (!r_found || (a_rdata.pri > r_best.pri));

    always_comb begin
        a_we    = 1'b0;
        a_waddr = slot_at(r_head, r_count);
        a_wdata = in_entry;
        a_raddr = r_head;
        b_we    = 1'b0;
        b_waddr = r_k;
        b_wdata = r_best;
        b_raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                a_we = accept && (t_kind'(s_axis_tuser) == KIND_INSERT) &&
                       (r_count < ADDR_W'(DEPTH - 1));
            end
            S_SCAN: begin
                a_raddr = slot_at(r_head, r_idx);
            end
            S_PICK: begin
                b_we = 1'b1;
            end
            S_COPY: begin
                a_we    = r_rd_vld;
                a_waddr = slot_at(r_head, r_rd_off);
                a_wdata = b_rdata;
            end
            default: begin
            end
        endcase
    end

    epq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_slots (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    epq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_sorted (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_k         <= '0;
            r_taken     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_out_entry <= '0;
                        unique case (t_kind'(s_axis_tuser))
                            KIND_INSERT: begin
                                r_out_valid <= 1'b1;
                                if (r_count < ADDR_W'(DEPTH - 1)) begin
                                    r_count    <= r_count + 1'b1;
                                    r_out_ok   <= 1'b1;
                                    r_out_held <= HELD_W'(r_count + 1'b1);
                                end else begin
                                    r_out_ok   <= 1'b0;
                                    r_out_held <= HELD_W'(r_count);
                                end
                            end
                            KIND_POP: begin
                                r_state <= S_POP;
                            end
                            KIND_CLEAR: begin
                                r_state  <= S_SCAN;
                                r_idx    <= '0;
                                r_rd_vld <= 1'b0;
                                r_found  <= 1'b0;
                                r_k      <= '0;
                                r_taken  <= '0;
                            end
                            KIND_NONE: begin
                                r_out_valid <= 1'b1;
                                r_out_ok    <= 1'b0;
                                r_out_held  <= HELD_W'(r_count);
                            end
                        endcase
                    end
                end
                S_POP: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    if (r_count != '0) begin
                        r_out_ok    <= 1'b1;
                        r_out_entry <= '{payload: a_rdata.payload,
                                         status:  ST_BUSY,
                                         pri:     a_rdata.pri,
                                         id:      a_rdata.id};
                        r_head      <= slot_at(r_head, ADDR_W'(1));
                        r_count     <= r_count - 1'b1;
                        r_out_held  <= HELD_W'(r_count - 1'b1);
                    end else begin
                        r_out_ok   <= 1'b0;
                        r_out_held <= HELD_W'(r_count);
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= issue;
                    r_rd_off <= r_idx;
                    if (issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (cand) begin
                        r_found    <= 1'b1;
                        r_best     <= a_rdata;
                        r_best_off <= r_rd_off;
                    end
                    if (done) begin
                        r_idx    <= '0;
                        r_state  <= r_found ? S_PICK : S_COPY;
                    end
                end
                S_PICK: begin
                    // best survivor goes to sorted position k
                    r_taken[r_best_off] <= 1'b1;
                    r_k                 <= r_k + 1'b1;
                    r_found             <= 1'b0;
                    r_state             <= S_SCAN;
                end
                S_COPY: begin
                    r_rd_vld <= issue;
                    r_rd_off <= r_idx;
                    if (issue) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (done) begin
                        r_state     <= S_IDLE;
                        r_count     <= r_k;
                        r_out_valid <= 1'b1;
                        r_out_ok    <= 1'b1;
                        r_out_entry <= '0;
                        r_out_held  <= HELD_W'(r_k);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_ok;
    assign m_axis_tdata  = {(OUT_W - HELD_W - ENTRY_W)'(0), r_out_held, r_out_entry};

endmodule

/* rtl/epq_checker.sv */
// port-level checks of the event queue and their bind to the top level
// depends on event_priority_queue_core_defines.svh and epq_pkg
`include "event_priority_queue_core_defines.svh"
module epq_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [epq_pkg::IN_W-1:0]  s_axis_tdata,
    input logic [1:0]                s_axis_tuser,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [epq_pkg::OUT_W-1:0] m_axis_tdata,
    input logic                      m_axis_tuser
);
    import epq_pkg::*;

    // a stalled result holds
    `EPQ_ASSERT(a_out_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    // one item in flight: no accept while a result waits
    `EPQ_ASSERT(a_one_item, i_clk, i_rst_n, (m_axis_tvalid |-> !s_axis_tready))
    // an accepted item closes the input until its result is out
    `EPQ_ASSERT(a_busy_after, i_clk, i_rst_n, (s_axis_tvalid && s_axis_tready |=> !s_axis_tready))
    // a nonzero returned state only comes from a good pop and is busy
    `EPQ_ASSERT(a_pop_busy, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tdata[17:16] != ST_DEAD) |-> m_axis_tuser && (m_axis_tdata[17:16] == ST_BUSY)))
    // reset empties the output side
    `EPQ_ASSERT_ALWAYS(a_reset_idle, i_clk, (!i_rst_n |=> !m_axis_tvalid))

endmodule

bind event_priority_queue_core epq_checker u_epq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
